// ----- design/mmo_pkg.sv -----
// mmo_pkg: types, codes and constant tables shared by the mono oscillator
// and its voice datapath and checker. No dependencies.
package mmo_pkg;

    localparam logic       OP_MIDI = 1'b0;
    localparam logic       OP_TICK = 1'b1;

    localparam logic [7:0] MIDI_NOTE_ON  = 8'h90;
    localparam logic [7:0] MIDI_NOTE_OFF = 8'h80;

    localparam logic [1:0] WAVE_SINE   = 2'd0;
    localparam logic [1:0] WAVE_SAW    = 2'd1;
    localparam logic [1:0] WAVE_SQUARE = 2'd2;

    localparam logic       CFG_WAVE_SHAPE  = 1'b0;
    localparam logic       CFG_OUTPUT_GAIN = 1'b1;

    localparam logic [1:0]  WAVE_SHAPE_RESET  = WAVE_SQUARE;
    localparam logic [15:0] OUTPUT_GAIN_RESET = 16'd19661;

    localparam logic signed [15:0] SQUARE_HIGH = 16'sd32767;
    localparam logic signed [15:0] SQUARE_LOW  = -16'sd32767;

    // top octave (notes 120..131) in Hz, unsigned Q16.16
    localparam logic [31:0] TOP_OCTAVE [12] = '{
        32'd548668578, 32'd581294109, 32'd615859655, 32'd652480563,
        32'd691279090, 32'd732384684, 32'd775934544, 32'd822074013,
        32'd870957077, 32'd922746880, 32'd977616265, 32'd1035748353
    };

    // quarter-wave polynomial coefficients, Q30
    localparam logic [63:0] COEF_A = 64'd1686629713;
    localparam logic [63:0] COEF_B = 64'd688904866;
    localparam logic [63:0] COEF_C = 64'd76016977;

    typedef struct packed {
        logic       op;
        logic [7:0] status_byte;
        logic [6:0] note_number;
        logic [6:0] velocity;
    } t_osc_in;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               sounding;
    } t_osc_out;

    typedef struct packed {
        logic    fire;
        t_osc_in item;
    } t_voice_req;

    typedef struct packed {
        logic signed [15:0] wave;
        logic               sounding;
    } t_voice_wave;

    // round(32767 * f(x)), x in Q16 within [0, 65536]; elaboration only
    function automatic logic [15:0] quarter_sine(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] inner;
        logic [63:0] t;
        logic [63:0] f;
        logic [63:0] v;
        x2    = (x * x) >> 16;
        inner = COEF_B - ((x2 * COEF_C) >> 16);
        t     = COEF_A - ((x2 * inner) >> 16);
        f     = (x * t) >> 16;
        v     = (f * 64'd32767 + (64'd1 << 29)) >> 30;
        return v[15:0];
    endfunction

endpackage

// ----- design/mmo_voice.sv -----
// mmo_voice: note tracking, phase accumulator and waveform lookup.
// Depends on mmo_pkg. Holds the increment and quarter-sine tables.
module mmo_voice #(
    parameter int PHASE_BITS     = 32,
    parameter int SINE_ADDR_BITS = 10,
    parameter int SAMPLE_HZ      = 48000
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mmo_pkg::t_voice_req  i_req,
    input  logic [1:0]           i_wave_shape,
    output mmo_pkg::t_voice_wave o_wave
);
    import mmo_pkg::*;

    localparam int QTR_BITS = SINE_ADDR_BITS - 2;
    localparam int QTR_SIZE = 1 << QTR_BITS;

    logic [PHASE_BITS-1:0]  step_rom [128];
    logic signed [15:0]     qrom [QTR_SIZE+1];

    for (genvar n = 0; n < 128; n++) begin : g_step
        localparam logic [63:0] FREQ = 64'(TOP_OCTAVE[n % 12]) >> (10 - n / 12);
        localparam logic [63:0] INC  =
            ((FREQ << (PHASE_BITS - 16)) + 64'(SAMPLE_HZ / 2)) / 64'(SAMPLE_HZ);
        assign step_rom[n] = INC[PHASE_BITS-1:0];
    end

    for (genvar q = 0; q <= QTR_SIZE; q++) begin : g_qsine
        localparam logic [15:0] QV = quarter_sine(64'(q) << (16 - QTR_BITS));
        assign qrom[q] = $signed(QV);
    end

    logic [PHASE_BITS-1:0] r_phase, n_phase;
    logic [6:0]            r_held, n_held;
    logic                  r_note_valid, n_note_valid;

    logic                      is_on, is_off;
    logic [SINE_ADDR_BITS-1:0] sine_addr;
    logic [1:0]                quad;
    logic [QTR_BITS:0]         pos;
    logic signed [15:0]        qval;
    logic signed [15:0]        wave;

    assign is_on  = (i_req.item.status_byte == MIDI_NOTE_ON) && (i_req.item.velocity != 7'd0);
    assign is_off = (i_req.item.status_byte == MIDI_NOTE_OFF) ||
                    (i_req.item.status_byte == MIDI_NOTE_ON);

    always_comb begin
        n_phase      = r_phase;
        n_held       = r_held;
        n_note_valid = r_note_valid;
        if (i_req.fire) begin
            if (i_req.item.op == OP_MIDI) begin
                if (is_on) begin
                    n_held       = i_req.item.note_number;
                    n_note_valid = 1'b1;
                end else if (is_off && r_note_valid && i_req.item.note_number == r_held) begin
                    n_note_valid = 1'b0;
                end
            end else if (r_note_valid) begin
                n_phase = r_phase + step_rom[r_held];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= '0;
            r_held       <= '0;
            r_note_valid <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_held       <= n_held;
            r_note_valid <= n_note_valid;
        end
    end

    // quarter-wave symmetry: mirror odd quadrants, negate the second half
    assign sine_addr = r_phase[PHASE_BITS-1 -: SINE_ADDR_BITS];
    assign quad      = sine_addr[SINE_ADDR_BITS-1 -: 2];
    assign pos       = quad[0] ? ((QTR_BITS+1)'(QTR_SIZE) - {1'b0, sine_addr[QTR_BITS-1:0]})
                               : {1'b0, sine_addr[QTR_BITS-1:0]};
    assign qval      = qrom[pos];

    always_comb begin
        case (i_wave_shape)
            WAVE_SINE: wave = quad[1] ? -qval : qval;
            WAVE_SAW:  wave = $signed({~r_phase[PHASE_BITS-1], r_phase[PHASE_BITS-2 -: 15]});
            default:   wave = r_phase[PHASE_BITS-1] ? SQUARE_LOW : SQUARE_HIGH;
        endcase
    end

    assign o_wave.wave     = r_note_valid ? wave : 16'sd0;
    assign o_wave.sounding = r_note_valid;

endmodule

// ----- design/midi_mono_oscillator.sv -----
// Monophonic MIDI oscillator, three-register pipeline around mmo_voice.
// Depends on mmo_pkg and mmo_voice.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) takes MIDI messages
//   (op 0) and sample ticks (op 1). Note-on (0x90, velocity nonzero) latches
//   a note; note-off (0x80, or 0x90 with velocity 0) for the held note clears
//   it. Each tick gives one transaction on the output channel (o_out_valid /
//   i_out_stall / o_out_data): a gain-scaled Q1.15 sample and the sounding
//   flag. MIDI messages give no output.
//   Throughput is one item per cycle while the receiver does not stall. A tick
//   passes the input register, the wave register (table lookup and phase
//   update) and the output register (one 16x16 multiply with rounding).
//   While the receiver stalls the output holds; the pipeline keeps filling
//   until all three registers are taken, then o_in_stall rises. MIDI messages
//   still pass while only the tick path is backed up behind them.
//   Configuration (i_cfg_*) is always ready; write it only while idle.
//   Reset clears the pipeline, releases the note, zeroes the phase and
//   loads square wave with gain 19661.
module midi_mono_oscillator #(
    parameter int PHASE_BITS     = 32,
    parameter int SINE_ADDR_BITS = 10,
    parameter int SAMPLE_HZ      = 48000
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  mmo_pkg::t_osc_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output mmo_pkg::t_osc_out o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [15:0]       i_cfg_data
);
    import mmo_pkg::*;

    logic [1:0]  r_wave_shape;
    logic [15:0] r_gain;

    logic        r_a_valid;
    t_osc_in     r_a_item;
    logic        r_b_valid;
    t_voice_wave r_b_wave;
    logic        r_c_valid;
    t_osc_out    r_c_data;

    logic        c_free, b_go, b_free, a_go, a_free, in_take;
    t_voice_req  voice_req;
    t_voice_wave voice_wave;

    logic               neg;
    logic [15:0]        mag;
    logic [31:0]        prod_rnd;
    logic [15:0]        rmag;
    logic signed [15:0] scaled;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_shape <= WAVE_SHAPE_RESET;
            r_gain       <= OUTPUT_GAIN_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WAVE_SHAPE:  r_wave_shape <= i_cfg_data[1:0];
                CFG_OUTPUT_GAIN: r_gain       <= i_cfg_data;
                default:         r_gain       <= r_gain;
            endcase
        end
    end

    // handshake chain, output back to input
    assign c_free  = !r_c_valid || !i_out_stall;
    assign b_go    = r_b_valid && c_free;
    assign b_free  = !r_b_valid || c_free;
    assign a_go    = r_a_valid && ((r_a_item.op == OP_MIDI) || b_free);
    assign a_free  = !r_a_valid || a_go;
    assign in_take = i_in_valid && a_free;
    assign o_in_stall = !a_free;

    assign voice_req.fire = a_go;
    assign voice_req.item = r_a_item;

    mmo_voice #(
        .PHASE_BITS     (PHASE_BITS),
        .SINE_ADDR_BITS (SINE_ADDR_BITS),
        .SAMPLE_HZ      (SAMPLE_HZ)
    ) u_voice (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (voice_req),
        .i_wave_shape (r_wave_shape),
        .o_wave       (voice_wave)
    );

    // sign-magnitude scaling, rounded half away from zero
    assign neg      = r_b_wave.wave[15];
    assign mag      = neg ? (~r_b_wave.wave + 16'd1) : r_b_wave.wave;
    assign prod_rnd = (mag * r_gain) + 32'd32768;
    assign rmag     = prod_rnd[31:16];
    assign scaled   = neg ? $signed(16'd0 - rmag) : $signed(rmag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (a_free) begin
                r_a_valid <= i_in_valid;
            end
            if (b_free) begin
                r_b_valid <= a_go && (r_a_item.op == OP_TICK);
            end
            if (c_free) begin
                r_c_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_a_item <= i_in_data;
        end
        if (b_free && a_go) begin
            r_b_wave <= voice_wave;
        end
        if (b_go) begin
            r_c_data.sample   <= scaled;
            r_c_data.sounding <= r_b_wave.sounding;
        end
    end

    assign o_out_valid = r_c_valid;
    assign o_out_data  = r_c_data;

endmodule

// ----- design/mmo_checker.sv -----
// mmo_checker: port-level assertions for midi_mono_oscillator, bound in below.
// Depends on mmo_pkg.
module mmo_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input mmo_pkg::t_osc_out o_out_data
);
    import mmo_pkg::*;

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("pipeline not empty after reset");

    // a silent transaction carries a zero sample
    a_silent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.sounding) |-> (o_out_data.sample == 16'sd0))
        else $error("nonzero sample while silent");

    // input backs up only behind a waiting result
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled with output free");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled output changed");

endmodule

bind midi_mono_oscillator mmo_checker u_mmo_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
